// ----- hdl/fsf_pkg.sv -----
// ----------------------------------------------------------------------------
// fsf_pkg
// Shared constants and codes for the four-sum finder.
// ----------------------------------------------------------------------------
package fsf_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int VW    = 32;
  localparam int SW    = VW + 2;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_FETCH = 2'd2;

  localparam logic [2:0] STAT_LOADED = 3'd0;
  localparam logic [2:0] STAT_FULL   = 3'd1;
  localparam logic [2:0] STAT_FOUND  = 3'd2;
  localparam logic [2:0] STAT_EXHAUST = 3'd3;
  localparam logic [2:0] STAT_CLEARED = 3'd4;

endpackage

// ----- hdl/four_sum_finder_unit.sv -----
// ----------------------------------------------------------------------------
// four_sum_finder_unit
// Sorted value store in a synchronous memory with a quadruplet search
// sequencer that resumes from a saved cursor on each fetch.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_*       in   tuser: mode[1:0]; tdata: value[31:0]
// m_*       out  tuser: status[2:0]; tdata: first, second, third, fourth,
//                stored_count, pad
// apb       in   target_sum at byte address 0
//
// clear resets count and cursors. load reads and compares each larger entry,
// shifting it up one place. fetch: data dependent; each (a, b, d) candidate
// scans the entries between b and d, all through the single memory read port.
// one item is worked at a time; a finished word waits in the output register.
// reset is synchronous and clears counts and cursors; no memory clearing pass.
// ----------------------------------------------------------------------------
module four_sum_finder_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // value[31:0]
  input  logic [1:0]   s_tuser,   // mode[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // first[31:0], second, third, fourth, stored_count[6:0], pad
  output logic [2:0]   m_tuser,   // status[2:0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW = fsf_pkg::AW;
  localparam int CW = fsf_pkg::CW;
  localparam int VW = fsf_pkg::VW;
  localparam int SW = fsf_pkg::SW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD_RD, ST_LD_CMP, ST_I_TOP, ST_I_PREV, ST_I_CHK,
    ST_J_TOP, ST_J_PREV, ST_J_CHK, ST_L_TOP, ST_L_SUM, ST_SCAN, ST_L_DEC, ST_PUT
  } state_t;

  state_t state;

  logic signed [VW-1:0] mem [fsf_pkg::DEPTH];
  logic signed [VW-1:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic signed [VW-1:0] wdata;
  logic we;

  logic signed [VW-1:0] target_sum;
  logic [CW-1:0] count, cur_first, cur_second, cur_fourth;
  logic exhausted;

  logic [CW-1:0] i, j, l, p, pidx;
  logic pend, hit_all, hit_bef;
  logic signed [VW-1:0] a, b, d, dprev, ld_val;
  logic signed [SW-1:0] need;
  logic [2:0] res_status;
  logic res_found;

  logic [CW-1:0] j_start, l_start;
  logic signed [SW-1:0] rdata_ext;

  assign rdata_ext = SW'(rdata);
  assign j_start = (i == cur_first && cur_second > i) ? cur_second : i + CW'(1);
  assign l_start = (i == cur_first && j == cur_second && cur_fourth > j + CW'(1)) ?
                   cur_fourth : j + CW'(2);

  assign s_tready = (state == ST_IDLE);
  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? 32'd0 : target_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      target_sum <= pwdata;
    end
  end

  // memory port control
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = p[AW-1:0];
    wdata = ld_val;
    case (state)
      ST_LD_RD: begin
        raddr = AW'(p - CW'(1));
        if (p == '0) we = 1'b1;
      end
      ST_LD_CMP: begin
        we = 1'b1;
        if (rdata > ld_val) wdata = rdata;
      end
      ST_I_TOP:  raddr = i[AW-1:0];
      ST_I_PREV: raddr = AW'(i - CW'(1));
      ST_J_TOP:  raddr = j[AW-1:0];
      ST_J_PREV: raddr = AW'(j - CW'(1));
      ST_L_TOP:  raddr = l[AW-1:0];
      ST_SCAN:   raddr = p[AW-1:0];
      default:   raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      cur_first  <= '0;
      cur_second <= '0;
      cur_fourth <= '0;
      exhausted  <= 1'b0;
      m_tvalid   <= 1'b0;
      pend       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_PUT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          res_found <= 1'b0;
          if (s_tvalid) begin
            ld_val <= s_tdata;
            p      <= count;
            case (s_tuser)
              fsf_pkg::MODE_CLEAR: begin
                count      <= '0;
                cur_first  <= '0;
                cur_second <= '0;
                cur_fourth <= '0;
                exhausted  <= 1'b0;
                res_status <= fsf_pkg::STAT_CLEARED;
                state      <= ST_PUT;
              end
              fsf_pkg::MODE_LOAD: begin
                if (count >= CW'(fsf_pkg::DEPTH)) begin
                  res_status <= fsf_pkg::STAT_FULL;
                  state      <= ST_PUT;
                end else begin
                  state <= ST_LD_RD;
                end
              end
              fsf_pkg::MODE_FETCH: begin
                if (exhausted) begin
                  res_status <= fsf_pkg::STAT_EXHAUST;
                  state      <= ST_PUT;
                end else begin
                  i     <= cur_first;
                  state <= ST_I_TOP;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_LD_RD: begin
          if (p == '0) begin
            count      <= count + CW'(1);
            cur_first  <= '0;
            cur_second <= '0;
            cur_fourth <= '0;
            exhausted  <= 1'b0;
            res_status <= fsf_pkg::STAT_LOADED;
            state      <= ST_PUT;
          end else begin
            state <= ST_LD_CMP;
          end
        end
        ST_LD_CMP: begin
          if (rdata > ld_val) begin
            p     <= p - CW'(1);
            state <= ST_LD_RD;
          end else begin
            count      <= count + CW'(1);
            cur_first  <= '0;
            cur_second <= '0;
            cur_fourth <= '0;
            exhausted  <= 1'b0;
            res_status <= fsf_pkg::STAT_LOADED;
            state      <= ST_PUT;
          end
        end
        ST_I_TOP: begin
          if (i >= count) begin
            exhausted  <= 1'b1;
            res_status <= fsf_pkg::STAT_EXHAUST;
            state      <= ST_PUT;
          end else begin
            state <= ST_I_PREV;
          end
        end
        ST_I_PREV: begin
          a     <= rdata;
          state <= ST_I_CHK;
        end
        ST_I_CHK: begin
          // skip a repeated first value
          if (i != '0 && rdata == a) begin
            i     <= i + CW'(1);
            state <= ST_I_TOP;
          end else begin
            j     <= j_start;
            state <= ST_J_TOP;
          end
        end
        ST_J_TOP: begin
          if (j >= count) begin
            i     <= i + CW'(1);
            state <= ST_I_TOP;
          end else begin
            state <= ST_J_PREV;
          end
        end
        ST_J_PREV: begin
          b     <= rdata;
          state <= ST_J_CHK;
        end
        ST_J_CHK: begin
          if (j != i + CW'(1) && rdata == b) begin
            j     <= j + CW'(1);
            state <= ST_J_TOP;
          end else begin
            l     <= l_start;
            state <= ST_L_TOP;
          end
        end
        ST_L_TOP: begin
          if (l >= count) begin
            j     <= j + CW'(1);
            state <= ST_J_TOP;
          end else begin
            state <= ST_L_SUM;
          end
        end
        ST_L_SUM: begin
          d       <= rdata;
          need    <= SW'(target_sum) - SW'(a) - SW'(b) - rdata_ext;
          p       <= j + CW'(1);
          pend    <= 1'b0;
          hit_all <= 1'b0;
          hit_bef <= 1'b0;
          state   <= ST_SCAN;
        end
        ST_SCAN: begin
          // one read issued per cycle, compared the cycle after
          if (p <= l - CW'(1)) begin
            pend <= 1'b1;
            pidx <= p;
            p    <= p + CW'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (rdata_ext == need) begin
              hit_all <= 1'b1;
              if (pidx != l - CW'(1)) hit_bef <= 1'b1;
            end
            if (pidx == l - CW'(1)) dprev <= rdata;
          end
          if (p > l - CW'(1) && !pend) state <= ST_L_DEC;
        end
        ST_L_DEC: begin
          // repeated fourth value already gave this quadruplet
          if (!hit_all || (l >= j + CW'(3) && dprev == d && hit_bef)) begin
            l     <= l + CW'(1);
            state <= ST_L_TOP;
          end else begin
            res_found  <= 1'b1;
            res_status <= fsf_pkg::STAT_FOUND;
            cur_first  <= i;
            cur_second <= j;
            cur_fourth <= l + CW'(1);
            state      <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {1'b0, count,
                         res_found ? d : 32'sd0,
                         res_found ? need[VW-1:0] : 32'd0,
                         res_found ? b : 32'sd0,
                         res_found ? a : 32'sd0};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(fsf_pkg::DEPTH)) else $error("store count beyond depth");

  a_found_sum: assert property (@(posedge clk) disable iff (rst)
    (state == ST_L_DEC && hit_all && res_status != fsf_pkg::STAT_FOUND) |->
    (SW'(a) + SW'(b) + need + SW'(d) == SW'(target_sum)))
    else $error("candidate sum mismatch");

  a_write_only_load: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_LD_RD || state == ST_LD_CMP))
    else $error("store written outside load");

  a_found_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == fsf_pkg::STAT_FOUND) |->
    ($signed(m_tdata[31:0]) <= $signed(m_tdata[63:32]) &&
     $signed(m_tdata[63:32]) <= $signed(m_tdata[95:64]) &&
     $signed(m_tdata[95:64]) <= $signed(m_tdata[127:96])))
    else $error("quadruplet out of order");

endmodule
